// ===== hw/rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, codes and helpers for the gradient histogram accumulator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SUM_W = 48;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_ACC      = 2'd1,
    REQ_READ     = 2'd2,
    REQ_READ_CLR = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [4:0] MISS_SLOT = 5'd16;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;
    logic latch;
    logic scan_start;
    logic scan_step;
    logic hist_rd;
    logic fin_look;
    logic fin_hist;
  } gha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic err;
    logic load;
    logic scan;
    logic scan_done;
    logic out_room;
  } gha_stat_t;

  // 48-bit accumulate with clamp; bit 48 of the result flags saturation
  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] acc,
                                             input logic [VAL_W-1:0] add);
    logic [SUM_W:0]   sum;
    logic [SUM_W-1:0] res;
    logic             ovf;
    sum = {acc[SUM_W-1], acc} + {{(SUM_W-VAL_W+1){add[VAL_W-1]}}, add};
    ovf = sum[SUM_W] != sum[SUM_W-1];
    if (!ovf) begin
      res = sum[SUM_W-1:0];
    end else if (sum[SUM_W]) begin
      res = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SUM_W-1){1'b1}}};
    end
    return {ovf, res};
  endfunction

endpackage

// ===== hw/rtl/gha_datapath.sv =====
// ----------------------------------------------------------------------------
// gha_datapath
// Request registers, split/count/histogram memories, split scan counter,
// saturating adders and the output register.
// ----------------------------------------------------------------------------
module gha_datapath #(
  parameter int NUM_FEATURES = 16,
  parameter int MAX_SPLITS   = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gha_pkg::gha_cmd_t       cmd,
  output gha_pkg::gha_stat_t      stat,
  input  logic [1:0]              req_type,
  input  logic [3:0]              feature_index,
  input  logic [4:0]              slot_index,
  input  logic signed [31:0]      feature_value,
  input  logic                    is_missing,
  input  logic signed [31:0]      gradient,
  input  logic signed [31:0]      curvature,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [47:0]      gradient_sum,
  output logic signed [47:0]      curvature_sum,
  output logic [4:0]              bin_index,
  output logic [1:0]              status
);
  import gha_pkg::*;

  localparam int SDEPTH = NUM_FEATURES * MAX_SPLITS;
  localparam int ROWS   = MAX_SPLITS + 2;
  localparam int HDEPTH = NUM_FEATURES * ROWS;
  localparam int FW     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int HA_W   = $clog2(HDEPTH);
  localparam int CW     = $clog2(MAX_SPLITS + 1);
  localparam int BW     = $clog2(ROWS);
  localparam logic [BW-1:0] MISS_ROW = BW'(MAX_SPLITS + 1);

  logic [CW-1:0]          cnt_mem [NUM_FEATURES];
  logic [VAL_W-1:0]       split_mem [SDEPTH];
  logic [2*SUM_W-1:0]     hist_mem [HDEPTH];

  logic [1:0]             req_q;
  logic [3:0]             feat_q;
  logic [4:0]             slot_q;
  logic signed [31:0]     val_q;
  logic                   miss_q;
  logic [31:0]            grad_q;
  logic [31:0]            curv_q;

  logic [CW-1:0]          cnt_rd;
  logic signed [31:0]     split_rd;
  logic [2*SUM_W-1:0]     hist_rd;
  logic [CW-1:0]          scan_idx;
  logic                   pend;
  logic [BW-1:0]          bin_q;
  logic [HA_W-1:0]        clr_addr;

  req_t                   req;
  logic [FW-1:0]          feat_ix;
  logic [SA_W-1:0]        sbase;
  logic [HA_W-1:0]        hbase;
  logic [HA_W-1:0]        h_addr;
  logic [SUM_W:0]         g_add;
  logic [SUM_W:0]         c_add;
  logic                   is_acc;
  logic                   hist_wr;
  logic                   feat_bad;
  logic                   load_bad;
  logic                   read_bad;

  assign req     = req_t'(req_q);
  assign feat_ix = FW'(feat_q);
  assign sbase   = SA_W'(feat_ix) * SA_W'(MAX_SPLITS);
  assign hbase   = HA_W'(feat_ix) * HA_W'(ROWS);
  assign h_addr  = hbase + HA_W'(bin_q);
  assign is_acc  = req == REQ_ACC;

  assign feat_bad = 32'(feat_q) >= NUM_FEATURES;
  assign load_bad = 32'(slot_q) >= MAX_SPLITS;
  assign read_bad = (slot_q != MISS_SLOT) && (32'(slot_q) > MAX_SPLITS);

  always_comb begin
    stat.clr_last  = clr_addr == HA_W'(HDEPTH - 1);
    stat.err       = feat_bad || (req == REQ_LOAD && load_bad) ||
                     ((req == REQ_READ || req == REQ_READ_CLR) && read_bad);
    stat.load      = req == REQ_LOAD;
    stat.scan      = is_acc && !miss_q;
    stat.scan_done = !pend && (scan_idx == cnt_rd);
    stat.out_room  = !out_valid || !out_stall;
  end

  assign g_add   = sat_add(hist_rd[2*SUM_W-1:SUM_W], grad_q);
  assign c_add   = sat_add(hist_rd[SUM_W-1:0], curv_q);
  assign hist_wr = cmd.fin_hist && (is_acc || req == REQ_READ_CLR);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q  <= req_type;
      feat_q <= feature_index;
      slot_q <= slot_index;
      val_q  <= feature_value;
      miss_q <= is_missing;
      grad_q <= gradient;
      curv_q <= curvature;
      cnt_rd <= cnt_mem[FW'(feature_index)];
    end
  end

  // split count memory
  always_ff @(posedge clk) begin
    if (cmd.clr_wr && (32'(clr_addr) < NUM_FEATURES)) begin
      cnt_mem[FW'(clr_addr)] <= '0;
    end else if (cmd.fin_look && stat.load && !stat.err) begin
      cnt_mem[feat_ix] <= CW'(slot_q) + CW'(1);
    end
  end

  // split value memory
  always_ff @(posedge clk) begin
    if (cmd.fin_look && stat.load && !stat.err) begin
      split_mem[sbase + SA_W'(slot_q)] <= val_q;
    end
    if (cmd.scan_step) begin
      split_rd <= split_mem[sbase + SA_W'(scan_idx)];
    end
  end

  // histogram memory; row MAX_SPLITS+1 of each feature is the missing bucket
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      hist_mem[clr_addr] <= '0;
    end else if (hist_wr) begin
      hist_mem[h_addr] <= is_acc ? {g_add[SUM_W-1:0], c_add[SUM_W-1:0]} : '0;
    end
    if (cmd.hist_rd) begin
      hist_rd <= hist_mem[h_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + HA_W'(1);
    end
  end

  // split scan: one read per cycle, compare lands in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.scan_start) begin
      pend <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= scan_idx != cnt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      if (is_acc) begin
        bin_q <= miss_q ? MISS_ROW : '0;
      end else begin
        bin_q <= (slot_q == MISS_SLOT) ? MISS_ROW : BW'(slot_q);
      end
    end else if (cmd.scan_step) begin
      if (scan_idx != cnt_rd) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (pend && split_rd <= val_q) begin
        bin_q <= bin_q + BW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_look || cmd.fin_hist) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_look) begin
      gradient_sum  <= '0;
      curvature_sum <= '0;
      bin_index     <= stat.err ? 5'd0 : slot_q;
      status        <= stat.err ? ST_RANGE : ST_OK;
    end else if (cmd.fin_hist) begin
      if (is_acc) begin
        gradient_sum  <= g_add[SUM_W-1:0];
        curvature_sum <= c_add[SUM_W-1:0];
        bin_index     <= miss_q ? MISS_SLOT : 5'(bin_q);
        status        <= (g_add[SUM_W] || c_add[SUM_W]) ? ST_SAT : ST_OK;
      end else begin
        gradient_sum  <= hist_rd[2*SUM_W-1:SUM_W];
        curvature_sum <= hist_rd[SUM_W-1:0];
        bin_index     <= slot_q;
        status        <= ST_OK;
      end
    end
  end

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step && !stat.scan_done |-> 32'(scan_idx) <= 32'(cnt_rd))
    else $error("split scan ran past split count");

  a_bin_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_hist && is_acc && !miss_q |-> 32'(bin_q) <= 32'(cnt_rd))
    else $error("bin above split count");

  a_no_double_fin: assert property (@(posedge clk) disable iff (rst)
    !(cmd.fin_look && cmd.fin_hist))
    else $error("two results in one cycle");

endmodule

// ===== hw/rtl/gha_ctrl.sv =====
// ----------------------------------------------------------------------------
// gha_ctrl
// Request sequencer: clearing pass, decode, split scan, histogram update.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gha_pkg::gha_stat_t stat,
  output gha_pkg::gha_cmd_t  cmd
);
  import gha_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_HRD   = 6'b010000,
    S_HWR   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.err || stat.load) begin
          if (stat.out_room) begin
            cmd.fin_look = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = stat.scan ? S_SCAN : S_HRD;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_HRD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HRD: begin
        cmd.hist_rd = 1'b1;
        state_next  = S_HWR;
      end
      S_HWR: begin
        if (stat.out_room) begin
          cmd.fin_hist = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_fin_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_look || cmd.fin_hist) |-> stat.out_room)
    else $error("result written over a pending transaction");

  a_latch_to_look: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == S_LOOK)
    else $error("accepted request not decoded");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cmd.latch && in_stall)
    else $error("request accepted during clearing pass");

endmodule

// ===== hw/rtl/gradient_histogram_accumulator.sv =====
// ----------------------------------------------------------------------------
// gradient_histogram_accumulator
// Per-feature gradient/curvature histograms for boosted-tree split search.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | req_type feature_index slot_index
//          |                    | feature_value is_missing gradient curvature
//  out     | out_valid/out_stall| gradient_sum curvature_sum bin_index status
//
//  Load and error requests finish in the decode state. Reads and missing-value
//  accumulates add a histogram read and write; accumulates with a value first
//  run the split scan, which reads one split per cycle from the single-port split
//  memory and then does the last compare.
//  After reset a clearing pass over all NUM_FEATURES*(MAX_SPLITS+2) histogram
//  rows zeroes the histograms and split counts; in_stall is high meanwhile.
//  A finished result sits in the output register; the next transaction is
//  taken while it waits, and work stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module gradient_histogram_accumulator #(
  parameter int NUM_FEATURES = 16,
  parameter int MAX_SPLITS   = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [3:0]         feature_index,
  input  logic [4:0]         slot_index,
  input  logic signed [31:0] feature_value,
  input  logic               is_missing,
  input  logic signed [31:0] gradient,
  input  logic signed [31:0] curvature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] gradient_sum,
  output logic signed [47:0] curvature_sum,
  output logic [4:0]         bin_index,
  output logic [1:0]         status
);
  import gha_pkg::*;

  gha_cmd_t  cmd;
  gha_stat_t stat;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gha_datapath #(
    .NUM_FEATURES (NUM_FEATURES),
    .MAX_SPLITS   (MAX_SPLITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .feature_index (feature_index),
    .slot_index    (slot_index),
    .feature_value (feature_value),
    .is_missing    (is_missing),
    .gradient      (gradient),
    .curvature     (curvature),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .gradient_sum  (gradient_sum),
    .curvature_sum (curvature_sum),
    .bin_index     (bin_index),
    .status        (status)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gradient_histogram_accumulator. It runs directed
// split loads, accumulates and reads, then random traffic and a short
// back-to-back burst on one missing bucket. An internal model predicts every
// result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gha_pkg::*;

  localparam int NFEAT      = 16;
  localparam int NSPLIT     = 15;
  localparam int CYCLE_CAP  = 2000000;
  localparam longint SMAX   = 64'sd140737488355327;
  localparam longint SMIN   = -64'sd140737488355328;

  typedef struct {
    req_t             req;
    logic [3:0]       feat;
    logic [4:0]       slot;
    logic [31:0]      value;
    logic             miss;
    logic [31:0]      grad;
    logic [31:0]      curv;
    bit               drain;   // wait for all results before sending
    bit               no_idle; // burst mode, no gaps or stalls
  } txn_t;

  typedef struct {
    logic [47:0] gsum;
    logic [47:0] csum;
    logic [4:0]  bin;
    logic [1:0]  st;
  } hist_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [3:0] feature_index = '0;
  logic [4:0] slot_index = '0;
  logic signed [31:0] feature_value = '0;
  logic is_missing = 1'b0;
  logic signed [31:0] gradient = '0;
  logic signed [31:0] curvature = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] gradient_sum;
  logic signed [47:0] curvature_sum;
  logic [4:0] bin_index;
  logic [1:0] status;

  gradient_histogram_accumulator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .feature_index(feature_index), .slot_index(slot_index),
    .feature_value(feature_value), .is_missing(is_missing),
    .gradient(gradient), .curvature(curvature),
    .out_valid(out_valid), .out_stall(out_stall),
    .gradient_sum(gradient_sum), .curvature_sum(curvature_sum),
    .bin_index(bin_index), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  txn_t      pending_q[$];
  hist_res_t sums_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        no_idle = 1'b0;

  // model state
  logic signed [31:0] m_split[NFEAT][NSPLIT];
  int                 m_count[NFEAT];
  longint             m_gh[NFEAT][NSPLIT+1];
  longint             m_ch[NFEAT][NSPLIT+1];
  longint             m_mg[NFEAT];
  longint             m_mc[NFEAT];

  // generator view of contiguous written split slots per feature
  int written[NFEAT];

  initial begin
    for (int f = 0; f < NFEAT; f++) begin
      m_count[f] = 0; m_mg[f] = 0; m_mc[f] = 0; written[f] = 0;
      for (int b = 0; b <= NSPLIT; b++) begin
        m_gh[f][b] = 0; m_ch[f][b] = 0;
      end
    end
  end

  function automatic longint clamp_add(longint acc, logic [31:0] add, ref bit sat);
    longint s;
    s = acc + longint'($signed(add));
    if (s > SMAX) begin
      sat = 1'b1;
      return SMAX;
    end
    if (s < SMIN) begin
      sat = 1'b1;
      return SMIN;
    end
    return s;
  endfunction

  task automatic predict_hist(input txn_t t);
    hist_res_t r;
    bit        sat;
    int        f;
    int        b;
    f = t.feat;
    sat = 1'b0;
    r = '{gsum: '0, csum: '0, bin: '0, st: ST_OK};
    case (t.req)
      REQ_LOAD: begin
        if (t.slot >= NSPLIT) begin
          r.st = ST_RANGE;
        end else begin
          m_split[f][t.slot] = t.value;
          m_count[f] = t.slot + 1;
          r.bin = t.slot;
        end
      end
      REQ_ACC: begin
        if (t.miss) begin
          m_mg[f] = clamp_add(m_mg[f], t.grad, sat);
          m_mc[f] = clamp_add(m_mc[f], t.curv, sat);
          r.gsum = m_mg[f][47:0];
          r.csum = m_mc[f][47:0];
          r.bin = MISS_SLOT;
        end else begin
          b = 0;
          for (int i = 0; i < m_count[f]; i++)
            if (m_split[f][i] <= $signed(t.value)) b++;
          m_gh[f][b] = clamp_add(m_gh[f][b], t.grad, sat);
          m_ch[f][b] = clamp_add(m_ch[f][b], t.curv, sat);
          r.gsum = m_gh[f][b][47:0];
          r.csum = m_ch[f][b][47:0];
          r.bin = 5'(b);
        end
        if (sat) r.st = ST_SAT;
      end
      default: begin
        if (t.slot == MISS_SLOT) begin
          r.gsum = m_mg[f][47:0];
          r.csum = m_mc[f][47:0];
          r.bin = MISS_SLOT;
          if (t.req == REQ_READ_CLR) begin
            m_mg[f] = 0; m_mc[f] = 0;
          end
        end else if (t.slot > NSPLIT) begin
          r.st = ST_RANGE;
        end else begin
          r.gsum = m_gh[f][t.slot][47:0];
          r.csum = m_ch[f][t.slot][47:0];
          r.bin = t.slot;
          if (t.req == REQ_READ_CLR) begin
            m_gh[f][t.slot] = 0; m_ch[f][t.slot] = 0;
          end
        end
      end
    endcase
    sums_q = {sums_q, r};
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    txn_t t;
    int   g;
    bit   take;
    if (!rst) begin
      take = in_valid && !in_stall;
      g = gap;
      if (take) begin
        t.req = req_t'(req_type); t.feat = feature_index; t.slot = slot_index;
        t.value = feature_value; t.miss = is_missing;
        t.grad = gradient; t.curv = curvature;
        predict_hist(t);
        g = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!(in_valid && in_stall)) begin
        if (g > 0) begin
          gap <= g - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && sums_q.size() > 0)) begin
          t = pending_q.pop_front();
          req_type <= t.req; feature_index <= t.feat; slot_index <= t.slot;
          feature_value <= t.value; is_missing <= t.miss;
          gradient <= t.grad; curvature <= t.curv;
          no_idle <= t.no_idle;
          gap <= 0;
          in_valid <= 1'b1;
        end else begin
          gap <= 0;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    hist_res_t e;
    int        n;
    if (!rst) begin
      n = stall_left;
      if (out_valid && !out_stall) begin
        if (sums_q.size() == 0) begin
          $error("result with no transaction outstanding: bin %0d", bin_index);
          errors++;
        end else begin
          e = sums_q.pop_front();
          if (gradient_sum !== e.gsum) begin
            $error("gradient_sum exp %h got %h", e.gsum, gradient_sum); errors++;
          end
          if (curvature_sum !== e.csum) begin
            $error("curvature_sum exp %h got %h", e.csum, curvature_sum); errors++;
          end
          if (bin_index !== e.bin) begin
            $error("bin_index exp %0d got %0d", e.bin, bin_index); errors++;
          end
          if (status !== e.st) begin
            $error("status exp %0d got %0d", e.st, status); errors++;
          end
        end
        n = no_idle ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) n = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        stall_left <= n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_txn(req_t rq, int f, int s, logic [31:0] v, bit ms,
                         logic [31:0] gr, logic [31:0] cv, bit dr = 0, bit ni = 0);
    txn_t t;
    t.req = rq; t.feat = 4'(f); t.slot = 5'(s); t.value = v; t.miss = ms;
    t.grad = gr; t.curv = cv; t.drain = dr; t.no_idle = ni;
    if (rq == REQ_LOAD && s < NSPLIT && s == written[f]) written[f] = s + 1;
    pending_q = {pending_q, t};
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2000) - 1000;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int f;
    int s;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: sorted splits with extremes, bins at both ends
    add_txn(REQ_ACC, 0, 0, 32'h0, 0, 32'h7fff_ffff, 32'h8000_0000);
    add_txn(REQ_LOAD, 0, 0, 32'h8000_0000, 0, 0, 0);
    add_txn(REQ_LOAD, 0, 1, 32'hffff_0000, 0, 0, 0);
    add_txn(REQ_LOAD, 0, 2, 32'h0001_0000, 0, 0, 0);
    add_txn(REQ_LOAD, 0, 3, 32'h7fff_ffff, 0, 0, 0);
    add_txn(REQ_ACC, 0, 0, 32'h8000_0000, 0, 32'h0001_0000, 32'h0000_8000);
    add_txn(REQ_ACC, 0, 0, 32'h7fff_ffff, 0, 32'hffff_ffff, 32'h0000_0001);
    add_txn(REQ_ACC, 0, 0, 32'h0000_0000, 1, 32'h1234_5678, 32'hffff_fffe);
    add_txn(REQ_LOAD, 0, 15, 32'h0, 0, 0, 0);
    add_txn(REQ_LOAD, 0, 31, 32'h0, 0, 0, 0);
    // unsorted splits
    add_txn(REQ_LOAD, 1, 0, 32'd50, 0, 0, 0);
    add_txn(REQ_LOAD, 1, 1, -32'sd50, 0, 0, 0);
    add_txn(REQ_LOAD, 1, 2, 32'd10, 0, 0, 0);
    add_txn(REQ_ACC, 1, 0, 32'd20, 0, 32'd7, 32'd9);
    // shrinking split count keeps histograms
    add_txn(REQ_LOAD, 0, 0, 32'h0, 0, 0, 0);
    add_txn(REQ_ACC, 0, 0, 32'h7fff_ffff, 0, 32'd3, 32'd4, 1);
    add_txn(REQ_READ, 0, 0, 0, 1, 32'hffff_ffff, 32'hffff_ffff);
    add_txn(REQ_READ, 0, 4, 0, 0, 0, 0);
    add_txn(REQ_READ, 0, 15, 0, 0, 0, 0);
    add_txn(REQ_READ_CLR, 0, 16, 0, 0, 0, 0);
    add_txn(REQ_READ, 0, 16, 0, 0, 0, 0);
    add_txn(REQ_READ_CLR, 0, 1, 0, 0, 0, 0);
    add_txn(REQ_READ, 0, 17, 0, 0, 0, 0);
    add_txn(REQ_READ_CLR, 15, 31, 0, 0, 0, 0);

    for (int k = 0; k < 1200; k++) begin
      f = $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 5);
      case ($urandom_range(0, 9))
        0, 1: begin
          s = $urandom_range(0, 20) == 0 ? $urandom_range(15, 31)
                                         : $urandom_range(0, written[f] < 14 ? written[f] : 14);
          add_txn(REQ_LOAD, f, s, rand_word(), 1'($urandom), $urandom, $urandom);
        end
        2: add_txn(REQ_READ, f, $urandom_range(0, 31), $urandom, 1'($urandom),
                   $urandom, $urandom, k == 600);
        3: add_txn(REQ_READ_CLR, f, $urandom_range(0, 3) == 0 ? 16 : $urandom_range(0, 31),
                   $urandom, 1'($urandom), $urandom, $urandom);
        default: add_txn(REQ_ACC, f, $urandom, rand_word(), $urandom_range(0, 4) == 0,
                         rand_word(), rand_word());
      endcase
    end

    // back-to-back accumulates into one missing bucket
    add_txn(REQ_READ_CLR, 15, 16, 0, 0, 0, 0, 1);
    for (int k = 0; k < 32; k++)
      add_txn(REQ_ACC, 15, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
    add_txn(REQ_READ_CLR, 15, 16, 0, 0, 0, 0, 1);

    while (pending_q.size() > 0 || in_valid || sums_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && sums_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
